### rtl/double_hash_key_addresser_defines.svh
// Assertion macros for the double hash key addresser.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef DOUBLE_HASH_KEY_ADDRESSER_DEFINES_SVH
`define DOUBLE_HASH_KEY_ADDRESSER_DEFINES_SVH

// Checked only outside reset.
`define DHKA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define DHKA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/dhka_pkg.sv
// Shared types, constants and hash step functions of the key addresser.
// No dependencies; used by every other file of the block but the defines header.
package dhka_pkg;

  localparam int unsigned HashW     = 32;
  localparam int unsigned SizeW     = 25;
  localparam int unsigned SlotW     = 24;
  localparam int unsigned CntW      = $clog2(HashW);
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [HashW-1:0] DjbSeed  = 32'd5381;
  localparam logic [SizeW-1:0] MaxSlots = 25'h1000000;

  typedef struct packed {
    logic [HashW-1:0] prim;
    logic [HashW-1:0] sec;
  } hash_pair_t;

  function automatic logic [HashW-1:0] djb_step(logic [HashW-1:0] h, logic [7:0] b);
    djb_step = (h << 5) + h + {{(HashW-8){1'b0}}, b};
  endfunction

  function automatic logic [HashW-1:0] oaat_step(logic [HashW-1:0] h, logic [7:0] b);
    logic [HashW-1:0] t;
    t = h + {{(HashW-8){1'b0}}, b};
    t = t + (t << 10);
    oaat_step = t ^ (t >> 6);
  endfunction

  function automatic logic [HashW-1:0] oaat_finish(logic [HashW-1:0] h);
    logic [HashW-1:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    oaat_finish = t + (t << 15);
  endfunction

  function automatic logic [SizeW-1:0] effective_size(logic [SizeW-1:0] s);
    priority if (s == '0) begin
      effective_size = {{(SizeW-1){1'b0}}, 1'b1};
    end else if (s > MaxSlots) begin
      effective_size = MaxSlots;
    end else begin
      effective_size = s;
    end
  endfunction

endpackage

### rtl/dhka_if.sv
// Channel interfaces of the key addresser: key bytes, results, configuration.
// Depends on dhka_pkg for field widths.
interface dhka_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       byte_valid;
  logic       last;
  modport source (output valid, key_byte, byte_valid, last, input ready);
  modport sink   (input valid, key_byte, byte_valid, last, output ready);
endinterface

interface dhka_res_if;
  logic                           valid;
  logic                           ready;
  logic [dhka_pkg::SlotW-1:0]     home_slot;
  logic [dhka_pkg::SlotW-1:0]     probe_step;
  logic [dhka_pkg::HashW-1:0]     primary_hash;
  logic [dhka_pkg::HashW-1:0]     secondary_hash;
  modport source (output valid, home_slot, probe_step, primary_hash, secondary_hash,
                  input ready);
  modport sink   (input valid, home_slot, probe_step, primary_hash, secondary_hash,
                  output ready);
endinterface

interface dhka_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [dhka_pkg::SizeW-1:0] table_size;
  modport source (output valid, table_size, input ready);
  modport sink   (input valid, table_size, output ready);
endinterface

### rtl/dhka_front.sv
// Front end: accumulates DJB2 and one-at-a-time hashes per key byte and
// finalizes them at the end of a key. Depends on dhka_pkg and dhka_if.
module dhka_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dhka_key_if.sink             key_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output dhka_pkg::hash_pair_t push_data_o
);

  logic [dhka_pkg::HashW-1:0] djb_q, djb_d, oaat_q, oaat_d;
  logic [dhka_pkg::HashW-1:0] djb_upd, oaat_upd;
  logic [dhka_pkg::HashW-1:0] pend_djb_q, pend_oaat_q;
  logic                       pend_valid_q, pend_valid_d;
  logic                       accept;

  assign key_i.ready = !pend_valid_q || push_ready_i;
  assign accept      = key_i.valid && key_i.ready;

  always_comb begin
    if (key_i.byte_valid) begin
      djb_upd  = dhka_pkg::djb_step(djb_q, key_i.key_byte);
      oaat_upd = dhka_pkg::oaat_step(oaat_q, key_i.key_byte);
    end else begin
      djb_upd  = djb_q;
      oaat_upd = oaat_q;
    end
  end

  always_comb begin
    djb_d        = djb_q;
    oaat_d       = oaat_q;
    pend_valid_d = pend_valid_q && !push_ready_i;
    if (accept) begin
      if (key_i.last) begin
        djb_d        = dhka_pkg::DjbSeed;
        oaat_d       = '0;
        pend_valid_d = 1'b1;
      end else begin
        djb_d  = djb_upd;
        oaat_d = oaat_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      djb_q        <= dhka_pkg::DjbSeed;
      oaat_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      djb_q        <= djb_d;
      oaat_q       <= oaat_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // The finished key is held here until the queue takes it; final mixing runs on the way out.
  always_ff @(posedge clk_i) begin
    if (accept && key_i.last) begin
      pend_djb_q  <= djb_upd;
      pend_oaat_q <= oaat_upd;
    end
  end

  assign push_valid_o     = pend_valid_q;
  assign push_data_o.prim = pend_djb_q;
  assign push_data_o.sec  = dhka_pkg::oaat_finish(pend_oaat_q);

endmodule

### rtl/dhka_fifo.sv
// Short queue of finished hash pairs between front and back end.
// Depends on dhka_pkg.
module dhka_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  dhka_pkg::hash_pair_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output dhka_pkg::hash_pair_t pop_data_o
);

  dhka_pkg::hash_pair_t           mem_q [dhka_pkg::FifoDepth];
  logic [dhka_pkg::FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [dhka_pkg::FifoCntW-1:0]  count_q;
  logic                           push, pop;

  assign push_ready_o = count_q != dhka_pkg::FifoCntW'(dhka_pkg::FifoDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### rtl/dhka_back.sv
// Back end: reduces both hashes modulo the table size with a shared-schedule
// restoring divider, one quotient bit per cycle. Depends on dhka_pkg, dhka_if.
module dhka_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  dhka_pkg::hash_pair_t       pop_data_i,
  input  logic [dhka_pkg::SizeW-1:0] size_i,
  dhka_res_if.source                 res_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StDone = 3'b100
  } state_e;

  localparam logic [dhka_pkg::CntW-1:0] LastBit = dhka_pkg::CntW'(dhka_pkg::HashW - 1);

  state_e                      state_q, state_d;
  logic [dhka_pkg::CntW-1:0]   cnt_q;
  dhka_pkg::hash_pair_t        hash_q, dvd_q;
  logic [dhka_pkg::SlotW-1:0]  rem_p_q, rem_s_q, rem_p_d, rem_s_d;
  logic [dhka_pkg::SizeW-1:0]  trial_p, trial_s;
  logic                        out_valid_q, out_load;

  assign pop_ready_o = state_q == StIdle;
  assign out_load    = (state_q == StDone) && (!out_valid_q || res_o.ready);

  // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial_p = {rem_p_q, dvd_q.prim[dhka_pkg::HashW-1]};
    trial_s = {rem_s_q, dvd_q.sec[dhka_pkg::HashW-1]};
    rem_p_d = (trial_p >= size_i) ? dhka_pkg::SlotW'(trial_p - size_i)
                                  : trial_p[dhka_pkg::SlotW-1:0];
    rem_s_d = (trial_s >= size_i) ? dhka_pkg::SlotW'(trial_s - size_i)
                                  : trial_s[dhka_pkg::SlotW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (pop_valid_i) state_d = StDiv;
      StDiv:   if (cnt_q == LastBit) state_d = StDone;
      StDone:  if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StDiv) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && pop_valid_i) begin
      hash_q  <= pop_data_i;
      dvd_q   <= pop_data_i;
      rem_p_q <= '0;
      rem_s_q <= '0;
    end else if (state_q == StDiv) begin
      dvd_q.prim <= dvd_q.prim << 1;
      dvd_q.sec  <= dvd_q.sec << 1;
      rem_p_q    <= rem_p_d;
      rem_s_q    <= rem_s_d;
    end
    if (out_load) begin
      res_o.home_slot      <= rem_p_q;
      res_o.probe_step     <= (rem_s_q == '0) ? dhka_pkg::SlotW'(1) : rem_s_q;
      res_o.primary_hash   <= hash_q.prim;
      res_o.secondary_hash <= hash_q.sec;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule

### rtl/double_hash_key_addresser.sv
// Double hash key addresser top level: front end, queue, back end, size register.
// Key bytes are taken one per cycle unless a finished key waits for the queue; a key's
// result passes the pending register, queue and modulo unit (32 divide steps).
// The bit-serial modulo unit takes no new key until its last result is registered out.
// Reset (asynchronous, active low) restores the seeds, empties the queue, sets size 1.
`include "double_hash_key_addresser_defines.svh"
module double_hash_key_addresser (
  input  logic       clk_i,
  input  logic       rst_ni,
  dhka_key_if.sink   key_i,
  dhka_cfg_if.sink   cfg_i,
  dhka_res_if.source res_o
);

  logic [dhka_pkg::SizeW-1:0] size_q;
  logic                       push_valid, push_ready, pop_valid, pop_ready;
  dhka_pkg::hash_pair_t       push_data, pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= dhka_pkg::SizeW'(1);
    end else if (cfg_i.valid) begin
      size_q <= dhka_pkg::effective_size(cfg_i.table_size);
    end
  end

  dhka_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  dhka_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  dhka_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .size_i      (size_q),
    .res_o       (res_o)
  );

  `DHKA_ASSERT(a_step_nonzero, res_o.valid |-> (res_o.probe_step != '0), "probe step is zero")
  `DHKA_ASSERT(a_home_in_range, res_o.valid |-> ({1'b0, res_o.home_slot} < size_q), "home slot out of range")
  `DHKA_ASSERT_ALWAYS(a_size_legal, (size_q != '0) && (size_q <= dhka_pkg::MaxSlots), "table size out of range")
  `DHKA_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !res_o.valid, "result during reset")

endmodule
